// ===== rtl/sfnc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfnc_pkg
// Shared types and constants for the strict file name checker.
// ----------------------------------------------------------------------------

package sfnc_pkg;

    // Width of one UTF-16 code unit
    localparam int CHAR_W = 16;

    // One input beat as held in the input register
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              is_last;
        logic              empty_name;
    } beat_t;

    // Verdict produced by the scanner for the beat it is stepping
    typedef struct packed {
        logic has_result;
        logic ok;
    } verdict_t;

endpackage

// ===== rtl/strict_file_name_checker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_file_name_checker_core
// Checks a single-segment file name streamed one UTF-16 unit per beat and
// returns one pass/fail verdict on the beat that ends the name.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  input   | in        | in_valid / in_stall | character, is_last, empty_name
//  result  | out       | out_valid/out_stall | name_ok
//
//  One beat per cycle sustained unless a name-ending beat is held behind a
//  stalled result. A name-ending beat passes through the input register and
//  then the result register before its verdict shows. Beats that do not end
//  a name never wait on the result side. Reset clears all valid flags and the
//  scan state. A stalled result holds its value; the input stalls only when a
//  name-ending beat is held behind a stalled result.

module strict_file_name_checker_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sfnc_pkg::CHAR_W-1:0] character,
    input  logic                        is_last,
    input  logic                        empty_name,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        name_ok
);
    import sfnc_pkg::*;

    beat_t    in_beat;
    beat_t    held_beat;
    logic     held_valid;
    logic     advance;
    logic     slot_free;
    logic     step;
    verdict_t verdict;

    logic out_valid_reg;
    logic out_valid_next;
    logic name_ok_reg;
    logic load_result;

    assign in_beat = '{character: character, is_last: is_last, empty_name: empty_name};

    // Move on when no result is due or the result register has room
    assign slot_free = !out_valid_reg || !out_stall;
    assign advance   = !(held_beat.is_last || held_beat.empty_name) || slot_free;
    assign step      = held_valid && advance;

    sfnc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_beat    (in_beat),
        .advance    (advance),
        .in_stall   (in_stall),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    sfnc_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .beat    (held_beat),
        .verdict (verdict)
    );

    // Result register
    assign load_result    = step && verdict.has_result;
    assign out_valid_next = load_result ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            name_ok_reg <= verdict.ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign name_ok   = name_ok_reg;

endmodule

// ===== rtl/sfnc_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfnc_in_reg
// Input register: captures one beat and holds it until the scanner takes it.
// ----------------------------------------------------------------------------

module sfnc_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  sfnc_pkg::beat_t in_beat,
    input  logic            advance,
    output logic            in_stall,
    output logic            held_valid,
    output sfnc_pkg::beat_t held_beat
);
    import sfnc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;
    logic  load;

    // Stall while a held beat cannot move on
    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (valid_reg && !advance);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= in_beat;
        end
    end

    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

endmodule

// ===== rtl/sfnc_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfnc_scan
// Per-name scan state and the single-pass verdict logic for one beat.
// ----------------------------------------------------------------------------

module sfnc_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  sfnc_pkg::beat_t    beat,
    output sfnc_pkg::verdict_t verdict
);
    import sfnc_pkg::*;

    localparam logic [CHAR_W-1:0] CH_CTRL_LIMIT = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_DOT        = 16'h002E;
    localparam logic [CHAR_W-1:0] CH_BSLASH     = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_SLASH      = 16'h002F;
    localparam logic [CHAR_W-1:0] CH_COLON      = 16'h003A;
    localparam logic [CHAR_W-1:0] CH_LT         = 16'h003C;
    localparam logic [CHAR_W-1:0] CH_GT         = 16'h003E;
    localparam logic [CHAR_W-1:0] CH_QUOTE      = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_BAR        = 16'h007C;
    localparam logic [CHAR_W-1:0] CH_QMARK      = 16'h003F;
    localparam logic [CHAR_W-1:0] CH_STAR       = 16'h002A;
    localparam logic [CHAR_W-1:0] CH_LOW_A      = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LOW_Z      = 16'h007A;
    localparam logic [CHAR_W-1:0] CH_CASE_DIFF  = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_DIGIT_1    = 16'h0031;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9    = 16'h0039;
    localparam logic [2:0]        POS_SAT       = 3'd5;
    localparam logic [2:0]        LEN_THREE     = 3'd3;
    localparam logic [2:0]        LEN_FOUR      = 3'd4;
    localparam int                HEAD_N        = 4;

    // Reserved device stems, three characters each
    localparam logic [3*CHAR_W-1:0] NAME_CON = {16'h0043, 16'h004F, 16'h004E};
    localparam logic [3*CHAR_W-1:0] NAME_PRN = {16'h0050, 16'h0052, 16'h004E};
    localparam logic [3*CHAR_W-1:0] NAME_AUX = {16'h0041, 16'h0055, 16'h0058};
    localparam logic [3*CHAR_W-1:0] NAME_NUL = {16'h004E, 16'h0055, 16'h004C};
    localparam logic [3*CHAR_W-1:0] NAME_COM = {16'h0043, 16'h004F, 16'h004D};
    localparam logic [3*CHAR_W-1:0] NAME_LPT = {16'h004C, 16'h0050, 16'h0054};

    function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            r = c - CH_CASE_DIFF;
        end
        return r;
    endfunction

    function automatic logic is_forbidden(input logic [CHAR_W-1:0] c);
        return (c < CH_CTRL_LIMIT) || c == CH_BSLASH || c == CH_SLASH ||
               c == CH_COLON || c == CH_LT || c == CH_GT || c == CH_QUOTE ||
               c == CH_BAR || c == CH_QMARK || c == CH_STAR;
    endfunction

    // State
    logic [2:0]        char_position_reg;
    logic [2:0]        char_position_next;
    logic [CHAR_W-1:0] first_chars_reg [HEAD_N];
    logic [CHAR_W-1:0] first_chars_next [HEAD_N];
    logic [2:0]        trimmed_len_reg;
    logic [2:0]        trimmed_len_next;
    logic              inside_stem_reg;
    logic              inside_stem_next;
    logic              bad_seen_reg;
    logic              bad_seen_next;

    // Values after this beat, before any end-of-name clear
    logic [CHAR_W-1:0]   c;
    logic [CHAR_W-1:0]   fc_upd [HEAD_N];
    logic [2:0]          len_upd;
    logic                inside_upd;
    logic                bad_upd;
    logic [2:0]          pos_upd;
    logic [3*CHAR_W-1:0] head3;
    logic                is_port_digit;
    logic                reserved;
    logic                name_end;

    assign c        = beat.character;
    assign name_end = beat.is_last || beat.empty_name;

    // Running updates for one character
    always_comb
    begin
        for (int i = 0; i < HEAD_N; i++)
        begin
            fc_upd[i] = (char_position_reg == 3'(i)) ? c : first_chars_reg[i];
        end
        bad_upd    = bad_seen_reg || is_forbidden(c);
        inside_upd = inside_stem_reg;
        len_upd    = trimmed_len_reg;
        if (inside_stem_reg)
        begin
            if (c == CH_DOT)
            begin
                inside_upd = 1'b0;
            end
            else if (c != CH_SPACE)
            begin
                len_upd = (char_position_reg < POS_SAT) ? char_position_reg + 3'd1 : POS_SAT;
            end
        end
        pos_upd = (char_position_reg < POS_SAT) ? char_position_reg + 3'd1 : POS_SAT;
    end

    // Reserved stem match on the folded head
    always_comb
    begin
        head3         = {fold_upper(fc_upd[0]), fold_upper(fc_upd[1]), fold_upper(fc_upd[2])};
        is_port_digit = (fc_upd[3] >= CH_DIGIT_1) && (fc_upd[3] <= CH_DIGIT_9);
        reserved      = 1'b0;
        if (len_upd == LEN_THREE)
        begin
            reserved = head3 == NAME_CON || head3 == NAME_PRN ||
                       head3 == NAME_AUX || head3 == NAME_NUL;
        end
        else if (len_upd == LEN_FOUR)
        begin
            reserved = (head3 == NAME_COM || head3 == NAME_LPT) && is_port_digit;
        end
    end

    // Verdict for the current beat
    always_comb
    begin
        verdict.has_result = name_end;
        verdict.ok         = !beat.empty_name && !bad_upd && c != CH_DOT &&
                             c != CH_SPACE && !reserved;
    end

    // Next state: clear at the end of every name
    always_comb
    begin
        char_position_next = char_position_reg;
        trimmed_len_next   = trimmed_len_reg;
        inside_stem_next   = inside_stem_reg;
        bad_seen_next      = bad_seen_reg;
        for (int i = 0; i < HEAD_N; i++)
        begin
            first_chars_next[i] = first_chars_reg[i];
        end
        if (step)
        begin
            if (name_end)
            begin
                char_position_next = '0;
                trimmed_len_next   = '0;
                inside_stem_next   = 1'b1;
                bad_seen_next      = 1'b0;
                for (int i = 0; i < HEAD_N; i++)
                begin
                    first_chars_next[i] = '0;
                end
            end
            else
            begin
                char_position_next = pos_upd;
                trimmed_len_next   = len_upd;
                inside_stem_next   = inside_upd;
                bad_seen_next      = bad_upd;
                for (int i = 0; i < HEAD_N; i++)
                begin
                    first_chars_next[i] = fc_upd[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_position_reg <= '0;
            trimmed_len_reg   <= '0;
            inside_stem_reg   <= 1'b1;
            bad_seen_reg      <= 1'b0;
            for (int i = 0; i < HEAD_N; i++)
            begin
                first_chars_reg[i] <= '0;
            end
        end
        else
        begin
            char_position_reg <= char_position_next;
            trimmed_len_reg   <= trimmed_len_next;
            inside_stem_reg   <= inside_stem_next;
            bad_seen_reg      <= bad_seen_next;
            for (int i = 0; i < HEAD_N; i++)
            begin
                first_chars_reg[i] <= first_chars_next[i];
            end
        end
    end

endmodule

// ===== rtl/sfnc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfnc_checker
// Port-level assertions for the strict file name checker, bound to the core.
// ----------------------------------------------------------------------------

module sfnc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic empty_name,
    input logic out_valid,
    input logic out_stall,
    input logic name_ok
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(name_ok))
        else $error("result beat changed while stalled");

    // Input back-pressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // A fresh result must follow an accepted input beat
    a_rise_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without a matching input beat");

    // An empty name is always rejected
    a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && $past(in_valid && !in_stall && empty_name, 2) |-> !name_ok)
        else $error("empty name accepted");

endmodule

bind strict_file_name_checker_core sfnc_checker u_sfnc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .empty_name (empty_name),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .name_ok    (name_ok)
);

// ===== verif/strict_file_name_checker_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_file_name_checker_core_tb
// Streams file names into the checker one UTF-16 unit per beat and compares
// every verdict with a local model of the naming rules. A short directed set
// covers device stems, a dot ending, an inner space, the NUL unit and empty names;
// random names follow, nearly half built around device stems, with random sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------

module strict_file_name_checker_core_tb;

    localparam int CW          = sfnc_pkg::CHAR_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BEATS = 400;

    // Characters with a meaning of their own in a name
    localparam logic [CW-1:0] CH_CTRL_LIMIT = 16'h0020;
    localparam logic [CW-1:0] CH_SPACE      = 16'h0020;
    localparam logic [CW-1:0] CH_DOT        = 16'h002E;
    localparam logic [CW-1:0] CH_ZERO       = 16'h0030;
    localparam logic [CW-1:0] CH_ONE        = 16'h0031;
    localparam logic [CW-1:0] CH_NINE       = 16'h0039;

    // Printable characters that are never allowed: \ / : < > " | ? *
    localparam logic [CW-1:0] BAD_PRINTABLE [9] = '{16'h5C, 16'h2F, 16'h3A, 16'h3C,
                                                     16'h3E, 16'h22, 16'h7C, 16'h3F,
                                                     16'h2A};
    // Values on either side of the class boundaries
    localparam logic [CW-1:0] EDGE_CHARS [8] = '{16'h1F, 16'h20, 16'h21, 16'h40,
                                                  16'h5B, 16'h60, 16'h7B, 16'h7F};

    // ------------------------------------------------------------------------
    // Verdict scoreboard: tracks the name in flight and queues its verdict
    // ------------------------------------------------------------------------
    class name_verdict_board;
        bit [2:0]    char_count;
        bit [CW-1:0] head [4];
        bit [2:0]    stem_len;
        bit          in_stem;
        bit          bad_seen;
        bit [CW-1:0] prev_char;
        bit          verdicts_due [$];
        int          verdicts;
        int          accepted;
        int          rejected;
        int          device_stems;
        int          failures;

        function new();
            clear_name();
        endfunction

        function void clear_name();
            char_count = '0;
            head       = '{default: '0};
            stem_len   = '0;
            in_stem    = 1'b1;
            bad_seen   = 1'b0;
            prev_char  = '0;
        endfunction

        // First three characters against a device word, ASCII case folded
        function bit head_is(string word);
            bit [CW-1:0] u;
            for (int i = 0; i < 3; i++)
            begin
                u = head[i];
                if (u >= 16'h61 && u <= 16'h7A)
                    u = u - 16'h20;
                if (u != CW'(word[i]))
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void take_beat(bit [CW-1:0] c, bit last, bit empty);
            bit device;
            bit ok;
            // empty name ends at once and is always refused
            if (empty)
            begin
                verdicts_due.push_back(1'b0);
                clear_name();
                return;
            end
            if (c < CH_CTRL_LIMIT || c inside {BAD_PRINTABLE})
                bad_seen = 1'b1;
            if (char_count < 4)
                head[char_count[1:0]] = c;
            // stem length ignores trailing spaces, stops at the first dot
            if (in_stem)
            begin
                if (c == CH_DOT)
                    in_stem = 1'b0;
                else if (c != CH_SPACE)
                    stem_len = (char_count < 5) ? char_count + 3'd1 : 3'd5;
            end
            if (char_count < 5)
                char_count++;
            prev_char = c;
            if (!last)
                return;
            device = 1'b0;
            if (stem_len == 3)
                device = head_is("CON") || head_is("PRN") || head_is("AUX") ||
                         head_is("NUL");
            else if (stem_len == 4)
                device = (head_is("COM") || head_is("LPT")) &&
                         head[3] >= CH_ONE && head[3] <= CH_NINE;
            if (device)
                device_stems++;
            ok = !bad_seen && prev_char != CH_DOT && prev_char != CH_SPACE && !device;
            verdicts_due.push_back(ok);
            clear_name();
        endfunction

        function void check_verdict(logic got);
            bit want;
            if (verdicts_due.size() == 0)
            begin
                $error("name_ok: unexpected verdict %0b with none expected", got);
                failures++;
                return;
            end
            want = verdicts_due.pop_front();
            verdicts++;
            if (want)
                accepted++;
            else
                rejected++;
            if (got !== want)
            begin
                $error("name_ok mismatch: expected %0b, actual %0b", want, got);
                failures++;
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [CW-1:0] character = '0;
    logic          is_last = 1'b0;
    logic          empty_name = 1'b0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          name_ok;

    name_verdict_board board = new();
    int                cycles = 0;
    int                beats_sent = 0;
    int                burst_left = 0;
    int                stall_mode = 0;
    int                mode_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    strict_file_name_checker_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .character  (character),
        .is_last    (is_last),
        .empty_name (empty_name),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .name_ok    (name_ok)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("strict_file_name_checker_core_tb: FAIL");
            $finish;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_verdict(name_ok);
    end

    // Receiver stall pattern: modes from never stalling to mostly stalling
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(32, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (mode_left % 16 < 6);
        endcase
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // One beat, with a random gap between bursts
    task automatic send_beat(logic [CW-1:0] c, logic last, logic empty);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid   <= 1'b1;
        character  <= c;
        is_last    <= last;
        empty_name <= empty;
        do
            @(posedge clk);
        while (in_stall);
        board.take_beat(c, last, empty);
        beats_sent++;
    endtask

    task automatic send_units(logic [CW-1:0] units [$]);
        for (int i = 0; i < units.size(); i++)
            send_beat(units[i], i == units.size() - 1, 1'b0);
    endtask

    task automatic send_text(string s);
        logic [CW-1:0] units [$];
        for (int i = 0; i < s.len(); i++)
            units.push_back(CW'(s[i]));
        send_units(units);
    endtask

    // Hold off until every verdict owed has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // Random character, weighted towards the classes that matter
    function automatic logic [CW-1:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return CW'(16'h41 + $urandom_range(0, 25)) +
                   ($urandom_range(0, 1) ? 16'h20 : 16'h0);
        else if (roll < 40)
            return CW'(CH_ZERO + $urandom_range(0, 9));
        else if (roll < 50)
            return CH_DOT;
        else if (roll < 58)
            return CH_SPACE;
        else if (roll < 66)
            return BAD_PRINTABLE[$urandom_range(0, 8)];
        else if (roll < 71)
            return CW'($urandom_range(0, 31));
        else if (roll < 78)
            return EDGE_CHARS[$urandom_range(0, 7)];
        return CW'($urandom_range(0, 16'hFFFF));
    endfunction

    // Name built round a device word, with case, digit, spaces and extension
    task automatic send_device_like();
        string         words [6] = '{"CON", "PRN", "AUX", "NUL", "COM", "LPT"};
        logic [CW-1:0] units [$];
        int            w;
        int            n;
        w = $urandom_range(0, 5);
        for (int i = 0; i < 3; i++)
            units.push_back(CW'(words[w][i]) + ($urandom_range(0, 1) ? 16'h20 : 16'h0));
        if (w >= 4)
        begin
            if ($urandom_range(0, 9) < 8)
                units.push_back(CW'(CH_ONE + $urandom_range(0, 8)));
            else
                units.push_back($urandom_range(0, 1) ? CH_ZERO : pick_char());
        end
        if ($urandom_range(0, 9) < 3)
        begin
            n = $urandom_range(1, 2);
            repeat (n) units.push_back(CH_SPACE);
        end
        if ($urandom_range(0, 9) < 4)
        begin
            units.push_back(CH_DOT);
            n = $urandom_range(0, 3);
            repeat (n) units.push_back(pick_char());
        end
        if ($urandom_range(0, 9) < 2)
            units[$urandom_range(0, units.size() - 1)] = pick_char();
        send_units(units);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CW-1:0] units [$];
        int            kind;
        int            len;
        bit            drained_mid;

        drained_mid = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed names
        send_beat(16'hFFFF, 1'b1, 1'b1);    // empty name, character ignored
        send_text("CON");
        send_text("lpt9");
        send_text("COM0");
        send_text("aux.c");
        send_text(".");
        send_text("a b");
        send_beat(16'h0000, 1'b0, 1'b0);    // NUL unit inside a name
        send_beat(16'h0041, 1'b1, 1'b0);
        send_beat(16'hFFFF, 1'b1, 1'b0);
        send_beat(16'h0061, 1'b0, 1'b0);    // name cut short by an empty mark
        send_beat(16'h0000, 1'b0, 1'b1);
        wait_drained();

        // random names
        while (beats_sent < RANDOM_BEATS + 30)
        begin
            if (!drained_mid && beats_sent > RANDOM_BEATS / 2)
            begin
                wait_drained();
                drained_mid = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 45)
                send_device_like();
            else if (kind < 85)
            begin
                units.delete();
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                  : $urandom_range(1, 6);
                repeat (len) units.push_back(pick_char());
                send_units(units);
            end
            else if (kind < 92)
                send_beat(CW'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)), 1'b1);
            else
            begin
                // broken name: a few units then an empty mark
                len = $urandom_range(0, 4);
                repeat (len) send_beat(pick_char(), 1'b0, 1'b0);
                send_beat(CW'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)), 1'b1);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Sent %0d beats; %0d verdicts checked, %0d accepted, %0d refused.",
                 beats_sent, board.verdicts, board.accepted, board.rejected);
        $display("Device stems matched: %0d; mismatches: %0d.",
                 board.device_stems, board.failures);
        if (board.failures == 0 && board.pending() == 0)
            $display("strict_file_name_checker_core_tb: PASS");
        else
            $display("strict_file_name_checker_core_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sfnc_pkg.sv
rtl/sfnc_in_reg.sv
rtl/sfnc_scan.sv
rtl/strict_file_name_checker_core.sv
rtl/sfnc_checker.sv
verif/strict_file_name_checker_core_tb.sv
